// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the deframer rtl
// needs a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FDC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("fdc assertion failed");
`define FDC_NEVER(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(prop)) \
		else $error("fdc forbidden condition seen");
`else
`define FDC_ASSERT(lbl, prop)
`define FDC_NEVER(lbl, prop)
`endif

`endif

// ===== hw/rtl/fdc_pkg.sv =====
// types and constants for the crc32c checked frame deframer
// used by fdc_crc_byte, fdc_parser and the top level
package fdc_pkg;

	localparam logic [31:0] CRC_POLY    = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
	localparam logic [4:0]  MAGIC_LAST  = 5'd3;
	localparam logic [4:0]  HDR_LAST    = 5'd23;
	localparam logic [4:0]  TRL_LAST    = 5'd3;
	localparam logic [31:0] CFG_MAGIC_RST = 32'd0;
	localparam logic [31:0] CFG_MAX_RST   = 32'd16777216;

	localparam logic [1:0] CFG_IDX_MAGIC = 2'd0;
	localparam logic [1:0] CFG_IDX_MAX   = 2'd1;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
	localparam logic [1:0] ST_TOO_LONG  = 2'd2;
	localparam logic [1:0] ST_CRC_BAD   = 2'd3;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_PAYLOAD = 3'b010,
		PH_TRAILER = 3'b100
	} phase_t;

	typedef struct packed {
		logic [31:0] expected_magic;
		logic [31:0] max_payload_bytes;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  version;
		logic [7:0]  msg_type;
		logic [15:0] flags;
		logic [63:0] request;
		logic [31:0] length;
		logic [7:0]  pbyte;
		logic [1:0]  status;
		logic        last;
	} result_t;

endpackage

// ===== hw/rtl/fdc_crc_byte.sv =====
// one-byte crc32c update, reflected polynomial, eight bit steps
// depends on fdc_pkg for the polynomial
module fdc_crc_byte
	import fdc_pkg::*;
(
	input  logic [31:0] crc,
	input  logic [7:0]  data,
	output logic [31:0] crc_next
);

	always_comb begin
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		crc_next = c;
	end

endmodule

// ===== hw/rtl/fdc_parser.sv =====
// frame parser state: header, payload and trailer phases, crc check
// depends on fdc_pkg and fdc_crc_byte
module fdc_parser
	import fdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data,
	input  cfg_t        cfg,
	output logic        res_valid,
	output result_t     res
);

	phase_t      phase_q, phase_d;
	logic [4:0]  pos_q, pos_d;
	logic [31:0] rem_q, rem_d;
	logic [31:0] crc_q, crc_d;
	logic [23:0] magic_q, magic_d;
	logic [7:0]  ver_q, ver_d;
	logic [7:0]  typ_q, typ_d;
	logic [15:0] flags_q, flags_d;
	logic [63:0] req_q, req_d;
	logic [23:0] len_q, len_d;
	logic [23:0] trl_q, trl_d;
	logic [31:0] crc_upd;
	logic [31:0] len_full;

	fdc_crc_byte u_crc (
		.crc      (crc_q),
		.data     (data),
		.crc_next (crc_upd)
	);

	assign len_full = {data, len_q};

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		rem_d     = rem_q;
		crc_d     = crc_q;
		magic_d   = magic_q;
		ver_d     = ver_q;
		typ_d     = typ_q;
		flags_d   = flags_q;
		req_d     = req_q;
		len_d     = len_q;
		trl_d     = trl_q;
		res       = '0;
		res_valid = 1'b0;
		unique case (phase_q)
			PH_PAYLOAD: begin
				crc_d     = crc_upd;
				res.kind  = KIND_PAYLOAD;
				res.pbyte = data;
				res_valid = 1'b1;
				rem_d     = rem_q - 32'd1;
				if (rem_q == 32'd1) begin
					phase_d = PH_TRAILER;
					pos_d   = '0;
				end
			end
			PH_TRAILER: begin
				if (pos_q < TRL_LAST) begin
					trl_d = {data, trl_q[23:8]};
					pos_d = pos_q + 5'd1;
				end else begin
					res.kind   = KIND_STATUS;
					res.status = ({data, trl_q} == ~crc_q) ? ST_OK : ST_CRC_BAD;
					res.last   = 1'b1;
					res_valid  = 1'b1;
					phase_d    = PH_HEADER;
					pos_d      = '0;
					rem_d      = '0;
					crc_d      = CRC_INIT;
				end
			end
			PH_HEADER: begin
				if (pos_q <= MAGIC_LAST) begin
					magic_d = {data, magic_q[23:8]};
					pos_d   = pos_q + 5'd1;
					if (pos_q == MAGIC_LAST && {data, magic_q} != cfg.expected_magic) begin
						res.kind   = KIND_STATUS;
						res.status = ST_BAD_MAGIC;
						res.last   = 1'b1;
						res_valid  = 1'b1;
						pos_d      = '0;
						crc_d      = CRC_INIT;
					end
				end else begin
					crc_d = crc_upd;
					pos_d = pos_q + 5'd1;
					case (pos_q)
						5'd4:  ver_d   = data;
						5'd5:  typ_d   = data;
						5'd6, 5'd7: flags_d = {data, flags_q[15:8]};
						5'd12, 5'd13, 5'd14, 5'd15,
						5'd16, 5'd17, 5'd18, 5'd19: req_d = {data, req_q[63:8]};
						5'd20, 5'd21, 5'd22: len_d = {data, len_q[23:8]};
						default: ;
					endcase
					if (pos_q == HDR_LAST) begin
						pos_d     = '0;
						res_valid = 1'b1;
						if (len_full > cfg.max_payload_bytes) begin
							res.kind   = KIND_STATUS;
							res.status = ST_TOO_LONG;
							res.last   = 1'b1;
							crc_d      = CRC_INIT;
						end else begin
							res.kind     = KIND_HEADER;
							res.version  = ver_q;
							res.msg_type = typ_q;
							res.flags    = flags_q;
							res.request  = req_q;
							res.length   = len_full;
							rem_d        = len_full;
							phase_d      = (len_full == 32'd0) ? PH_TRAILER : PH_PAYLOAD;
						end
					end
				end
			end
			default: begin
				phase_d = PH_HEADER;
				pos_d   = '0;
				rem_d   = '0;
				crc_d   = CRC_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			rem_q   <= '0;
			crc_q   <= CRC_INIT;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			rem_q   <= rem_d;
			crc_q   <= crc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			magic_q <= magic_d;
			ver_q   <= ver_d;
			typ_q   <= typ_d;
			flags_q <= flags_d;
			req_q   <= req_d;
			len_q   <= len_d;
			trl_q   <= trl_d;
		end
	end

endmodule

// ===== hw/rtl/frame_deframer_crc32c_check_unit.sv =====
// top level of the crc32c checked frame deframer
// depends on fdc_pkg, fdc_parser, fdc_crc_byte and assert_macros.svh
//
// usage:
//  rx channel (rx_valid, rx_stall, rx_byte) carries one stream byte per word.
//  res channel (res_valid, res_stall and the result fields) carries one
//  result word: a decoded header, a payload byte or a frame end status.
//  header bytes, magic and trailer bytes before the last give no result.
//  cfg_we writes cfg_data to register cfg_index (0 magic, 1 max payload,
//  others ignored); the user writes only while the block is idle, unchecked.
// timing:
//  a byte goes through an input register and the parser into the result
//  register, which raises res_valid when it takes a result.
//  one byte per cycle sustained while res_stall is low; the crc32c byte
//  update and parser decision are combinational between the two registers.
// reset: both registers empty, parser waits for a header, magic reads 0 and
//  max payload 16777216.
// stall: the result register holds; rx_stall rises while the input
//  register is full and the result register cannot drain.
`include "assert_macros.svh"

module frame_deframer_crc32c_check_unit
	import fdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  message_version,
	output logic [7:0]  message_type,
	output logic [15:0] message_flags,
	output logic [63:0] request_id,
	output logic [31:0] payload_length,
	output logic [7:0]  payload_byte,
	output logic [1:0]  frame_status,
	output logic        last_of_frame
);

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        step;
	logic        prs_valid;
	result_t     prs_res;
	logic        out_valid_q;
	result_t     out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_magic    <= CFG_MAGIC_RST;
			cfg_q.max_payload_bytes <= CFG_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IDX_MAGIC: cfg_q.expected_magic    <= cfg_data;
				CFG_IDX_MAX:   cfg_q.max_payload_bytes <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = !out_valid_q || !res_stall;
	assign rx_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	fdc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data      (byte_s1),
		.cfg       (cfg_q),
		.res_valid (prs_valid),
		.res       (prs_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && prs_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && prs_valid) begin
			out_q <= prs_res;
		end
	end

	assign res_valid       = out_valid_q;
	assign result_kind     = out_q.kind;
	assign message_version = out_q.version;
	assign message_type    = out_q.msg_type;
	assign message_flags   = out_q.flags;
	assign request_id      = out_q.request;
	assign payload_length  = out_q.length;
	assign payload_byte    = out_q.pbyte;
	assign frame_status    = out_q.status;
	assign last_of_frame   = out_q.last;

	`FDC_ASSERT(a_stall_only_when_blocked, rx_stall |-> (res_valid && res_stall))
	`FDC_ASSERT(a_result_lands, (step && prs_valid) |=> res_valid)
	`FDC_ASSERT(a_last_is_status, res_valid |-> (last_of_frame == (result_kind == KIND_STATUS)))
	`FDC_NEVER(a_no_kind3, res_valid && result_kind > KIND_STATUS)

endmodule
